FILE: hw/rtl/siq_pkg.sv
package siq_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_DRAINED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  typedef struct packed {
    logic insert;
    logic load_empty;
    logic drain;
  } siq_cmd_t;

  typedef struct packed {
    logic empty;
    logic one_left;
    logic full;
  } siq_stat_t;

endpackage

FILE: hw/rtl/siq_in_if.sv
interface siq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [siq_pkg::DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

FILE: hw/rtl/siq_out_if.sv
interface siq_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [siq_pkg::DATA_W-1:0] out_value;
  logic [1:0]                       status;
  logic                             last;

  modport source (output valid, output out_value, output status, output last, input ready);
  modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

FILE: hw/rtl/sorted_insert_queue.sv
// Insert: the status word is registered and valid in the cycle after the input word is taken;
// inserts go at one per cycle while the output register is free, set by the row of compare-and-shift cells.
// Drain of n entries: the controller first enters its drain state, after which words leave the shifting store
// at one per cycle while the output register is free; the next input can be taken in the cycle the last one leaves.
// Reset (rst, synchronous) clears the entry count, the controller state and
// output valid; the stored words are not reset.
module sorted_insert_queue #(
  parameter int CAPACITY = siq_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  siq_in_if.sink    in_ch,
  siq_out_if.source out_ch
);

  siq_pkg::siq_cmd_t  cmd;
  siq_pkg::siq_stat_t stat;

  siq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  siq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_value  (in_ch.value),
    .out_value (out_ch.out_value),
    .status    (out_ch.status),
    .last      (out_ch.last)
  );

endmodule

FILE: hw/rtl/siq_ctrl.sv
module siq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_mode,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  siq_pkg::siq_stat_t stat,
  output siq_pkg::siq_cmd_t  cmd
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic can_load;
  logic accept;

  assign can_load = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && can_load;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == siq_pkg::MODE_INSERT) begin
            cmd.insert = 1'b1;
          end else if (stat.empty) begin
            cmd.load_empty = 1'b1;
          end else begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // One stored word leaves per cycle while the output register is free.
        if (can_load) begin
          cmd.drain = 1'b1;
          if (stat.one_left) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.insert || cmd.load_empty || cmd.drain) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("input ready outside idle state");

  a_drain_state: assert property (@(posedge clk) disable iff (rst)
    cmd.drain |-> state == S_DRAIN)
    else $error("drain command outside drain state");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> !stat.empty)
    else $error("drain state with an empty store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(cmd.insert || cmd.load_empty || cmd.drain))
    else $error("output register loaded while its word is held");

  a_drain_entry: assert property (@(posedge clk) disable iff (rst)
    (accept && in_mode == siq_pkg::MODE_DRAIN && !stat.empty) |=> state == S_DRAIN)
    else $error("drain of a filled store did not start");

endmodule

FILE: hw/rtl/siq_dp.sv
module siq_dp #(
  parameter int CAPACITY = siq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  siq_pkg::siq_cmd_t                 cmd,
  output siq_pkg::siq_stat_t                stat,
  input  logic signed [siq_pkg::DATA_W-1:0] in_value,
  output logic signed [siq_pkg::DATA_W-1:0] out_value,
  output logic [1:0]                        status,
  output logic                              last
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [siq_pkg::DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]               gt;
  logic [CW-1:0]                     count;

  assign stat.empty    = (count == '0);
  assign stat.one_left = (count == CW'(1));
  assign stat.full     = (count >= CW'(CAPACITY));

  // Each cell compares its own word with the new value. Since the store is
  // descending, gt forms a run of ones from cell 0 up to the insert point.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign gt[i] = (CW'(i) < count) && (entries[i] > in_value);

    always_ff @(posedge clk) begin
      if (cmd.insert && !gt[i]) begin
        if (i == 0) begin
          entries[i] <= in_value;
        end else if (gt[(i == 0) ? 0 : i-1]) begin
          entries[i] <= in_value;
        end else begin
          entries[i] <= entries[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.drain && i < CAPACITY-1) begin
        entries[i] <= entries[(i < CAPACITY-1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert && !stat.full) begin
      count <= count + CW'(1);
    end else if (cmd.drain) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      out_value <= '0;
      status    <= stat.full ? siq_pkg::ST_DROPPED : siq_pkg::ST_INSERTED;
      last      <= 1'b1;
    end else if (cmd.load_empty) begin
      out_value <= '0;
      status    <= siq_pkg::ST_EMPTY;
      last      <= 1'b1;
    end else if (cmd.drain) begin
      out_value <= entries[0];
      status    <= siq_pkg::ST_DRAINED;
      last      <= stat.one_left;
    end
  end

endmodule
